// ===== hw/rtl/asf_pkg.sv =====
package asf_pkg;

	localparam int MaxIntervals = 64;
	localparam int IdW          = 16;
	localparam int TimeW        = 32;
	localparam int OrdW         = 6;

	typedef struct packed {
		logic                     valid;
		logic [IdW-1:0]           id;
		logic signed [TimeW-1:0]  st;
		logic signed [TimeW-1:0]  fin;
	} asf_entry_t;

	typedef struct packed {
		logic insert;
		logic drain;
	} asf_cmd_t;

endpackage

// ===== hw/rtl/asf_cell.sv =====
module asf_cell
	import asf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  asf_cmd_t    cmd,
	input  asf_entry_t  new_item,
	input  asf_entry_t  left_entry,
	input  logic        left_shift,
	input  asf_entry_t  right_entry,
	output asf_entry_t  entry,
	output logic        shift
);

	logic                    valid_q;
	logic [IdW-1:0]          id_q;
	logic signed [TimeW-1:0] st_q;
	logic signed [TimeW-1:0] fin_q;

	// A held interval finishing later than the new one moves one place right.
	assign shift = cmd.insert && valid_q && (fin_q > new_item.fin);

	assign entry.valid = valid_q;
	assign entry.id    = id_q;
	assign entry.st    = st_q;
	assign entry.fin   = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.drain) begin
			valid_q <= right_entry.valid;
		end else if (cmd.insert && !valid_q && (left_shift || left_entry.valid)) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain) begin
			id_q  <= right_entry.id;
			st_q  <= right_entry.st;
			fin_q <= right_entry.fin;
		end else if (cmd.insert) begin
			if (left_shift && (shift || !valid_q)) begin
				id_q  <= left_entry.id;
				st_q  <= left_entry.st;
				fin_q <= left_entry.fin;
			end else if (shift || (!valid_q && left_entry.valid)) begin
				// first cell that holds a later finish, or the first empty cell: take the new item
				id_q  <= new_item.id;
				st_q  <= new_item.st;
				fin_q <= new_item.fin;
			end
		end
	end

endmodule

// ===== hw/rtl/activity_selection_by_finish_unit.sv =====
// channel  | handshake                 | payload
// ---------+---------------------------+-------------------------------------------------
// input    | start, accepted if !busy  | interval_id, start_time, finish_time, is_last
// result   | result_valid, one cycle   | chosen_id, chosen_start, chosen_finish, ordinal,
//          |                           | last_of_run, overflowed
//
// Each item is inserted into the sorted cell chain, or dropped if the chain is full.
// After an item marked last, the chain drains one cell per cycle into the selector;
// busy stays high until the chain is empty.
// Results appear during the drain, the final one in the cycle busy falls.
// Reset empties the chain and clears the drop flag; the receiver cannot stall.
module activity_selection_by_finish_unit
	import asf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [IdW-1:0]           interval_id,
	input  logic signed [TimeW-1:0]  start_time,
	input  logic signed [TimeW-1:0]  finish_time,
	input  logic                     is_last,
	output logic                     result_valid,
	output logic [IdW-1:0]           chosen_id,
	output logic signed [TimeW-1:0]  chosen_start,
	output logic signed [TimeW-1:0]  chosen_finish,
	output logic [OrdW-1:0]          ordinal,
	output logic                     last_of_run,
	output logic                     overflowed
);

	typedef enum logic {IDLE, EMIT} state_t;

	state_t                  state_q;
	logic                    drop_q;
	logic                    res_valid_q;
	logic                    res_last_q;
	logic                    res_ovf_q;
	logic [IdW-1:0]          res_id_q;
	logic signed [TimeW-1:0] res_st_q;
	logic signed [TimeW-1:0] res_fin_q;
	logic [OrdW-1:0]         res_ord_q;
	logic                    pend_valid_q;
	logic [IdW-1:0]          pend_id_q;
	logic signed [TimeW-1:0] pend_st_q;
	logic signed [TimeW-1:0] pend_fin_q;
	logic [OrdW-1:0]         pend_ord_q;
	logic [OrdW-1:0]         sel_cnt_q;

	logic       accept;
	logic       full;
	asf_cmd_t   cmd;
	asf_entry_t new_item;
	asf_entry_t head;
	logic       take;
	asf_entry_t cells [MaxIntervals];
	logic       shifts [MaxIntervals];

	assign busy     = (state_q == EMIT);
	assign accept   = start && !busy;
	assign full     = cells[MaxIntervals-1].valid;
	assign head     = cells[0];

	assign new_item.valid = 1'b1;
	assign new_item.id    = interval_id;
	assign new_item.st    = start_time;
	assign new_item.fin   = finish_time;

	assign cmd.insert = accept && !full;
	assign cmd.drain  = busy;

	genvar g;
	generate
		for (g = 0; g < MaxIntervals; g++) begin : g_cell
			asf_entry_t left_e;
			asf_entry_t right_e;
			logic       left_s;
			if (g == 0) begin : g_first
				assign left_e = '{valid: 1'b1, id: '0, st: '0, fin: '0};
				assign left_s = 1'b0;
			end else begin : g_mid
				assign left_e = cells[g-1];
				assign left_s = shifts[g-1];
			end
			if (g == MaxIntervals - 1) begin : g_tail
				assign right_e = '{valid: 1'b0, id: '0, st: '0, fin: '0};
			end else begin : g_inner
				assign right_e = cells[g+1];
			end
			asf_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.new_item   (new_item),
				.left_entry (left_e),
				.left_shift (left_s),
				.right_entry(right_e),
				.entry      (cells[g]),
				.shift      (shifts[g])
			);
		end
	endgenerate

	// select the head if it is the first or starts after the last selected finish
	assign take = head.valid && (!pend_valid_q || (head.st > pend_fin_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			drop_q       <= 1'b0;
			res_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			sel_cnt_q    <= '0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						drop_q <= drop_q | full;
						if (is_last) begin
							state_q <= EMIT;
						end
					end
				end
				EMIT: begin
					if (!head.valid) begin
						// chain empty: flush the held selection as the final result
						res_valid_q  <= pend_valid_q;
						res_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						sel_cnt_q    <= '0;
						drop_q       <= 1'b0;
						state_q      <= IDLE;
					end else if (take) begin
						res_valid_q  <= pend_valid_q;
						res_last_q   <= 1'b0;
						pend_valid_q <= 1'b1;
						sel_cnt_q    <= sel_cnt_q + 1'b1;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (busy && (take || !head.valid)) begin
			res_id_q  <= pend_id_q;
			res_st_q  <= pend_st_q;
			res_fin_q <= pend_fin_q;
			res_ord_q <= pend_ord_q;
			res_ovf_q <= drop_q;
		end
		if (busy && take) begin
			pend_id_q  <= head.id;
			pend_st_q  <= head.st;
			pend_fin_q <= head.fin;
			pend_ord_q <= sel_cnt_q;
		end
	end

	assign result_valid  = res_valid_q;
	assign chosen_id     = res_id_q;
	assign chosen_start  = res_st_q;
	assign chosen_finish = res_fin_q;
	assign ordinal       = res_ord_q;
	assign last_of_run   = res_last_q;
	assign overflowed    = res_ovf_q;

endmodule

// ===== hw/rtl/asf_checker.sv =====
module asf_checker
	import asf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic is_last,
	input logic result_valid,
	input logic last_of_run
);

	// busy only rises after an item marked last was taken
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && is_last))
		else $error("busy rose without a last item");

	a_last_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && is_last |=> busy)
		else $error("last item did not start selection");

	a_mid_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_of_run |-> busy)
		else $error("non-final result while idle");

	a_final_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_of_run |-> !busy)
		else $error("final result while still busy");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !is_last |=> !result_valid)
		else $error("result after a plain item");

endmodule

bind activity_selection_by_finish_unit asf_checker u_asf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.is_last     (is_last),
	.result_valid(result_valid),
	.last_of_run (last_of_run)
);

// ===== dv/tb.sv =====
module tb
	import asf_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [IdW-1:0]          id;
		logic signed [TimeW-1:0] st;
		logic signed [TimeW-1:0] fin;
	} interval_t;

	typedef struct {
		logic [IdW-1:0]          id;
		logic signed [TimeW-1:0] st;
		logic signed [TimeW-1:0] fin;
		logic [OrdW-1:0]         ord;
		logic                    last;
		logic                    ovf;
	} pick_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [IdW-1:0]          interval_id = '0;
	logic signed [TimeW-1:0] start_time = '0;
	logic signed [TimeW-1:0] finish_time = '0;
	logic                    is_last = 1'b0;
	logic                    result_valid;
	logic [IdW-1:0]          chosen_id;
	logic signed [TimeW-1:0] chosen_start;
	logic signed [TimeW-1:0] chosen_finish;
	logic [OrdW-1:0]         ordinal;
	logic                    last_of_run;
	logic                    overflowed;

	// predicted contents of the sorted store
	interval_t held [MaxIntervals];
	int        held_n = 0;
	logic      dropped = 1'b0;

	pick_t expected_picks[$];
	int    errors = 0;
	bit    steady = 1'b0;

	activity_selection_by_finish_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.interval_id  (interval_id),
		.start_time   (start_time),
		.finish_time  (finish_time),
		.is_last      (is_last),
		.result_valid (result_valid),
		.chosen_id    (chosen_id),
		.chosen_start (chosen_start),
		.chosen_finish(chosen_finish),
		.ordinal      (ordinal),
		.last_of_run  (last_of_run),
		.overflowed   (overflowed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		errors++;
	endtask

	function automatic void insert_by_finish(input interval_t iv);
		int pos;
		if (held_n >= MaxIntervals) begin
			dropped = 1'b1;
			return;
		end
		pos = held_n;
		// equal finish times stay behind earlier arrivals
		while (pos > 0 && held[pos-1].fin > iv.fin)
			pos--;
		for (int k = held_n; k > pos; k--)
			held[k] = held[k-1];
		held[pos] = iv;
		held_n++;
	endfunction

	function automatic void select_by_finish();
		logic signed [TimeW-1:0] bound;
		int    picked;
		bit    have_prev;
		pick_t prev;
		picked = 0;
		have_prev = 1'b0;
		bound = '0;
		for (int i = 0; i < held_n; i++) begin
			if (picked == 0 || held[i].st > bound) begin
				// hold each pick until we know whether it closes the run
				if (have_prev)
					expected_picks.push_back(prev);
				prev.id = held[i].id;
				prev.st = held[i].st;
				prev.fin = held[i].fin;
				prev.ord = OrdW'(picked);
				prev.last = 1'b0;
				prev.ovf = dropped;
				have_prev = 1'b1;
				bound = held[i].fin;
				picked++;
			end
		end
		if (have_prev) begin
			prev.last = 1'b1;
			expected_picks.push_back(prev);
		end
		held_n = 0;
		dropped = 1'b0;
	endfunction

	task automatic pause_sender();
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// called at a rising edge; waits for the edge that accepts the item, then may pause the sender
	task automatic send_interval(input logic [IdW-1:0] id, input logic signed [TimeW-1:0] st,
			input logic signed [TimeW-1:0] fin, input logic last);
		interval_t iv;
		iv.id = id;
		iv.st = st;
		iv.fin = fin;
		start <= 1'b1;
		interval_id <= id;
		start_time <= st;
		finish_time <= fin;
		is_last <= last;
		do @(posedge clk); while (busy);
		insert_by_finish(iv);
		if (last)
			select_by_finish();
		pause_sender();
	endtask

	always @(posedge clk) begin
		pick_t want;
		if (arst_n && result_valid === 1'b1) begin
			if (expected_picks.size() == 0) begin
				report_mismatch($sformatf("unexpected result id %h", chosen_id));
			end else begin
				want = expected_picks.pop_front();
				if (chosen_id !== want.id)
					report_mismatch($sformatf("chosen_id %h exp %h", chosen_id, want.id));
				if (chosen_start !== want.st)
					report_mismatch($sformatf("chosen_start %0d exp %0d id %h",
						chosen_start, want.st, want.id));
				if (chosen_finish !== want.fin)
					report_mismatch($sformatf("chosen_finish %0d exp %0d id %h",
						chosen_finish, want.fin, want.id));
				if (ordinal !== want.ord)
					report_mismatch($sformatf("ordinal %0d exp %0d id %h",
						ordinal, want.ord, want.id));
				if (last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run %b exp %b id %h",
						last_of_run, want.last, want.id));
				if (overflowed !== want.ovf)
					report_mismatch($sformatf("overflowed %b exp %b id %h",
						overflowed, want.ovf, want.id));
			end
		end
	end

	task automatic test_single_intervals();
		send_interval(16'h0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
		send_interval(16'hffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
		send_interval(16'h5555, -32'sd1, 32'sd0, 1'b1);
		send_interval(16'haaaa, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
	endtask

	// out-of-order finishes, equal finishes, and a start touching the last finish
	task automatic test_finish_order();
		steady = 1'b1;
		send_interval(16'd1, 32'sd0, 32'sd10, 1'b0);
		send_interval(16'd2, 32'sd5, 32'sd3, 1'b0);
		send_interval(16'd3, -32'sd20, -32'sd5, 1'b0);
		send_interval(16'd4, 32'sd11, 32'sd20, 1'b0);
		send_interval(16'd5, 32'sd10, 32'sd20, 1'b0);
		steady = 1'b0;
		send_interval(16'd6, 32'sd20, 32'sd30, 1'b0);
		send_interval(16'd7, 32'sd21, 32'sd40, 1'b1);
	endtask

	task automatic test_signed_extremes();
		send_interval(16'd8, 32'sh8000_0000, -32'sd100, 1'b0);
		send_interval(16'd9, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
		send_interval(16'd10, -32'sd99, 32'sd5, 1'b0);
		send_interval(16'd11, 32'sh7fff_fffe, 32'sh8000_0000, 1'b1);
	endtask

	// a full store of disjoint intervals, inserted latest finish first
	task automatic test_full_run();
		for (int i = MaxIntervals - 1; i >= 0; i--)
			send_interval(IdW'(i), TimeW'(10 * i), TimeW'(10 * i + 5), i == 0);
	endtask

	function automatic logic signed [TimeW-1:0] narrow_time();
		return TimeW'(int'($urandom_range(0, 60)) - 30);
	endfunction

	task automatic send_random_set(input int n, input bit wide);
		logic signed [TimeW-1:0] st;
		logic signed [TimeW-1:0] fin;
		for (int i = 0; i < n; i++) begin
			if (wide) begin
				st = $urandom();
				fin = $urandom();
			end else begin
				st = narrow_time();
				fin = st + TimeW'(int'($urandom_range(0, 12)) - 2);
			end
			send_interval(IdW'($urandom_range(0, 65535)), st, fin, i == n - 1);
		end
	endtask

	task automatic test_store_full();
		send_random_set(MaxIntervals + 6, 1'b0);
		// the dropped item itself closes the set
		send_random_set(MaxIntervals + 1, 1'b0);
		// drop flag must be clear again
		send_random_set(3, 1'b0);
	endtask

	task automatic test_random_sets();
		int sent;
		int n;
		int r;
		sent = 0;
		while (sent < 250) begin
			r = $urandom_range(0, 99);
			if (r < 75)
				n = $urandom_range(1, 8);
			else if (r < 95)
				n = $urandom_range(9, MaxIntervals);
			else
				n = $urandom_range(MaxIntervals + 1, MaxIntervals + 6);
			steady = ($urandom_range(0, 4) == 0);
			send_random_set(n, $urandom_range(0, 3) == 0);
			sent += n;
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_intervals();
		test_finish_order();
		test_signed_extremes();
		test_full_run();
		test_store_full();
		test_random_sets();
		start <= 1'b0;
		while (expected_picks.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== activity_selection_by_finish_unit.f =====
hw/rtl/asf_pkg.sv
hw/rtl/asf_cell.sv
hw/rtl/activity_selection_by_finish_unit.sv
hw/rtl/asf_checker.sv
dv/tb.sv
